>>> rtl/core/ort_pkg.sv
// Shared widths, types and rounding helpers for the orientation restraint
// torque block. No dependencies; compile first.

package ort_pkg;

	localparam int QW   = 16;  // quaternion component, Q2.14
	localparam int IDXW = 16;  // particle index
	localparam int KW   = 31;  // force constant and energy, Q15.16
	localparam int TW   = 32;  // torque component, Q15.16
	localparam int RAWW = 34;  // unrounded axis component, Q.28
	localparam int AXW  = 22;  // rounded axis component, Q.16
	localparam int SUMW = 43;  // dot and cross sums, Q.32
	localparam int MAGW = 26;  // magnitude of d and of a cross component, Q.16
	localparam int DDW  = 2 * MAGW;     // d squared, Q.32
	localparam int GW   = KW + MAGW + 1; // magnitude of 2kd, Q.32
	localparam int GHW  = GW / 2;       // split point of the 2kd partial products
	localparam int PPW  = GHW + MAGW;   // one partial product
	localparam int PSW  = GW + MAGW + 1; // full torque product plus carry room
	localparam int EW   = 33;  // 1 - d squared, Q.32, up to exactly one
	localparam int EPW  = KW + 32;      // k times the lower part of e
	localparam int QSH  = 32;  // fraction bits dropped from the Q.48 products

	localparam logic [KW-1:0] TQ_MAX = '1;

	typedef struct packed {
		logic signed [RAWW-1:0] x;
		logic signed [RAWW-1:0] y;
		logic signed [RAWW-1:0] z;
	} raw_axis_t;

	typedef struct packed {
		logic signed [AXW-1:0] x;
		logic signed [AXW-1:0] y;
		logic signed [AXW-1:0] z;
	} axis_t;

	// sign and rounded magnitude
	typedef struct packed {
		logic            neg;
		logic [MAGW-1:0] mag;
	} sm_t;

	// load strobes of the back stages, shared with the torque lanes
	typedef struct packed {
		logic ld_s6;
		logic ld_s7;
		logic ld_s8;
	} stage_en_t;

	// body x axis turned into the space frame, exact in Q.28
	function automatic raw_axis_t axis_raw(input logic signed [QW-1:0] s,
		input logic signed [QW-1:0] a, input logic signed [QW-1:0] b,
		input logic signed [QW-1:0] c);
		logic signed [2*QW-1:0] ss, aa, bb, cc, ab, sc, ac, sb;
		raw_axis_t r;
		ss = s * s;
		aa = a * a;
		bb = b * b;
		cc = c * c;
		ab = a * b;
		sc = s * c;
		ac = a * c;
		sb = s * b;
		r.x = RAWW'(ss) + RAWW'(aa) - RAWW'(bb) - RAWW'(cc);
		r.y = (RAWW'(ab) + RAWW'(sc)) <<< 1;
		r.z = (RAWW'(ac) - RAWW'(sb)) <<< 1;
		return r;
	endfunction

	// Q.28 to Q.16, ties away from zero; the result never exceeds 2^20 in size
	function automatic logic signed [AXW-1:0] round_axis(input logic signed [RAWW-1:0] v);
		logic [RAWW-1:0] m;
		logic [RAWW-1:0] r;
		logic signed [AXW-1:0] t;
		m = v[RAWW-1] ? RAWW'(-v) : RAWW'(v);
		r = (m + (RAWW'(1) << 11)) >> 12;
		t = AXW'(r);
		return v[RAWW-1] ? -t : t;
	endfunction

	// Q.32 to Q.16, ties away from zero, kept as sign and magnitude
	function automatic sm_t round_q16(input logic signed [SUMW-1:0] v);
		logic [SUMW-1:0] m;
		logic [SUMW-1:0] r;
		sm_t o;
		m = v[SUMW-1] ? SUMW'(-v) : SUMW'(v);
		r = (m + (SUMW'(1) << 15)) >> 16;
		o.neg = v[SUMW-1];
		o.mag = MAGW'(r);
		return o;
	endfunction

endpackage

>>> rtl/core/ort_in_if.sv
// Request channel of the orientation restraint block: particle index and
// the current and reference quaternions. Depends on ort_pkg.

interface ort_in_if;
	logic                          valid;
	logic                          ready;
	logic [ort_pkg::IDXW-1:0]      particle_index;
	logic signed [ort_pkg::QW-1:0] cur_s;
	logic signed [ort_pkg::QW-1:0] cur_vx;
	logic signed [ort_pkg::QW-1:0] cur_vy;
	logic signed [ort_pkg::QW-1:0] cur_vz;
	logic signed [ort_pkg::QW-1:0] ref_s;
	logic signed [ort_pkg::QW-1:0] ref_vx;
	logic signed [ort_pkg::QW-1:0] ref_vy;
	logic signed [ort_pkg::QW-1:0] ref_vz;

	modport source (output valid, particle_index, cur_s, cur_vx, cur_vy, cur_vz,
		ref_s, ref_vx, ref_vy, ref_vz, input ready);
	modport sink (input valid, particle_index, cur_s, cur_vx, cur_vy, cur_vz,
		ref_s, ref_vx, ref_vy, ref_vz, output ready);
endinterface

>>> rtl/core/ort_out_if.sv
// Result channel of the orientation restraint block: index, energy and
// torque. Depends on ort_pkg.

interface ort_out_if;
	logic                          valid;
	logic                          ready;
	logic [ort_pkg::IDXW-1:0]      result_index;
	logic [ort_pkg::KW-1:0]        energy;
	logic signed [ort_pkg::TW-1:0] torque_x;
	logic signed [ort_pkg::TW-1:0] torque_y;
	logic signed [ort_pkg::TW-1:0] torque_z;

	modport source (output valid, result_index, energy, torque_x, torque_y, torque_z,
		input ready);
	modport sink (input valid, result_index, energy, torque_x, torque_y, torque_z,
		output ready);
endinterface

>>> rtl/core/ort_cfg_if.sv
// Configuration write channel: carries the force constant.
// Depends on ort_pkg.

interface ort_cfg_if;
	logic                   valid;
	logic                   ready;
	logic [ort_pkg::KW-1:0] force_constant;

	modport source (output valid, force_constant, input ready);
	modport sink (input valid, force_constant, output ready);
endinterface

>>> rtl/core/ort_torque_lane.sv
// One torque component: split product of |2kd| and |cross|, rounding,
// saturation and sign. Stages 6 to 8 of the pipeline. Depends on ort_pkg.

module ort_torque_lane (
	input  logic                           clk,
	input  ort_pkg::stage_en_t             ld,
	input  logic [ort_pkg::GW-1:0]         gmag_s5,
	input  logic [ort_pkg::MAGW-1:0]       cmag_s5,
	input  logic                           neg_s5,
	output logic signed [ort_pkg::TW-1:0]  torque_s8
);

	localparam int GW   = ort_pkg::GW;
	localparam int GHW  = ort_pkg::GHW;
	localparam int PPW  = ort_pkg::PPW;
	localparam int PSW  = ort_pkg::PSW;
	localparam int KW   = ort_pkg::KW;
	localparam int TW   = ort_pkg::TW;
	localparam int QSH  = ort_pkg::QSH;
	localparam logic [PSW-1:0] ROUND_HALF = PSW'(1) << (QSH - 1);

	logic [PPW-1:0] hi_prod, lo_prod;
	logic [PPW-1:0] hi_s6, lo_s6;
	logic           neg_s6;
	logic [PSW-1:0] psum;
	logic [KW-1:0]  tmag_s7;
	logic           sat_s7, neg_s7;
	logic [KW-1:0]  mag_sel;
	logic signed [TW-1:0] tq_mag;

	always_comb begin
		hi_prod = gmag_s5[GW-1:GHW] * cmag_s5;
		lo_prod = gmag_s5[GHW-1:0] * cmag_s5;
		psum    = (PSW'(hi_s6) << GHW) + PSW'(lo_s6) + ROUND_HALF;
		mag_sel = sat_s7 ? ort_pkg::TQ_MAX : tmag_s7;
		tq_mag  = TW'(mag_sel);
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s6) begin
			hi_s6  <= hi_prod;
			lo_s6  <= lo_prod;
			neg_s6 <= neg_s5;
		end
		if (ld.ld_s7) begin
			// anything at or above 2^31 after rounding clamps
			sat_s7  <= |psum[PSW-1:QSH+KW];
			tmag_s7 <= psum[QSH+KW-1:QSH];
			neg_s7  <= neg_s6;
		end
		if (ld.ld_s8) begin
			torque_s8 <= neg_s7 ? -tq_mag : tq_mag;
		end
	end

endmodule

>>> rtl/core/orientation_restraint_torque_top.sv
// Throughput: one request per cycle while results are taken; every
// stage has its own ready, so a stalled result holds only the stages
// behind it that are full.
// Reset (arst_n low) empties the pipeline and clears the force constant to 0.
// The eight register stages are bounded by the 16x16 and 22x22 multipliers
// and the split 58x26 torque product.
module orientation_restraint_torque_top (
	input  logic clk,
	input  logic arst_n,
	ort_in_if.sink    item,
	ort_out_if.source result,
	ort_cfg_if.sink   cfg
);

	localparam int IDXW = ort_pkg::IDXW;
	localparam int KW   = ort_pkg::KW;
	localparam int TW   = ort_pkg::TW;
	localparam int SUMW = ort_pkg::SUMW;
	localparam int AXW  = ort_pkg::AXW;
	localparam int MAGW = ort_pkg::MAGW;
	localparam int DDW  = ort_pkg::DDW;
	localparam int GW   = ort_pkg::GW;
	localparam int EW   = ort_pkg::EW;
	localparam int EPW  = ort_pkg::EPW;
	localparam int QSH  = ort_pkg::QSH;
	localparam logic [EW-1:0]  E_ONE      = EW'(1) << QSH;
	localparam logic [EPW-1:0] ROUND_HALF = EPW'(1) << (QSH - 1);

	logic [KW-1:0] k_q;

	// valid and ready per stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;
	ort_pkg::stage_en_t ld;

	logic [IDXW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7, idx_s8;

	ort_pkg::raw_axis_t cur_raw_s1, ref_raw_s1;
	ort_pkg::axis_t     nc_s2, nr_s2;
	logic signed [SUMW-1:0] dot_s3;
	logic signed [SUMW-1:0] crs_s3 [3];
	ort_pkg::sm_t       d_s4;
	ort_pkg::sm_t       c_s4 [3];
	logic [DDW-1:0]     dd_s5;
	logic [GW-1:0]      gmag_s5;
	logic [MAGW-1:0]    cmag_s5 [3];
	logic               neg_s5 [3];
	logic [EW-1:0]      e_s6;
	logic [KW-1:0]      en_s7, en_s8;
	logic signed [TW-1:0] torque_s8 [3];

	logic signed [2*AXW-1:0] pxx, pyy, pzz, pyz, pzy, pzx, pxz, pxy, pyx;
	logic [GW-2:0]  kd;
	logic [EW-1:0]  e_next;
	logic [EPW-1:0] eprod, esum;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			k_q <= cfg.force_constant;
		end
	end

	// a stage takes new data when empty or when the next one takes its own
	assign rdy_s8 = !v_s8 || result.ready;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign item.ready = rdy_s1;

	assign ld.ld_s6 = rdy_s6;
	assign ld.ld_s7 = rdy_s7;
	assign ld.ld_s8 = rdy_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= item.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
		end
	end

	// arithmetic between stages
	always_comb begin
		pxx = nc_s2.x * nr_s2.x;
		pyy = nc_s2.y * nr_s2.y;
		pzz = nc_s2.z * nr_s2.z;
		pyz = nc_s2.y * nr_s2.z;
		pzy = nc_s2.z * nr_s2.y;
		pzx = nc_s2.z * nr_s2.x;
		pxz = nc_s2.x * nr_s2.z;
		pxy = nc_s2.x * nr_s2.y;
		pyx = nc_s2.y * nr_s2.x;

		kd = k_q * d_s4.mag;

		// d squared above one leaves no energy
		if (dd_s5[DDW-1:QSH] != '0) begin
			e_next = '0;
		end else begin
			e_next = E_ONE - EW'(dd_s5[QSH-1:0]);
		end

		// e of exactly one gives k itself
		if (e_s6[EW-1]) begin
			eprod = {k_q, {QSH{1'b0}}};
		end else begin
			eprod = k_q * e_s6[QSH-1:0];
		end
		esum = eprod + ROUND_HALF;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			idx_s1     <= item.particle_index;
			cur_raw_s1 <= ort_pkg::axis_raw(item.cur_s, item.cur_vx, item.cur_vy, item.cur_vz);
			ref_raw_s1 <= ort_pkg::axis_raw(item.ref_s, item.ref_vx, item.ref_vy, item.ref_vz);
		end
		if (rdy_s2) begin
			idx_s2  <= idx_s1;
			nc_s2.x <= ort_pkg::round_axis(cur_raw_s1.x);
			nc_s2.y <= ort_pkg::round_axis(cur_raw_s1.y);
			nc_s2.z <= ort_pkg::round_axis(cur_raw_s1.z);
			nr_s2.x <= ort_pkg::round_axis(ref_raw_s1.x);
			nr_s2.y <= ort_pkg::round_axis(ref_raw_s1.y);
			nr_s2.z <= ort_pkg::round_axis(ref_raw_s1.z);
		end
		if (rdy_s3) begin
			idx_s3    <= idx_s2;
			dot_s3    <= SUMW'(pxx) + SUMW'(pyy) + SUMW'(pzz);
			crs_s3[0] <= SUMW'(pyz) - SUMW'(pzy);
			crs_s3[1] <= SUMW'(pzx) - SUMW'(pxz);
			crs_s3[2] <= SUMW'(pxy) - SUMW'(pyx);
		end
		if (rdy_s4) begin
			idx_s4  <= idx_s3;
			d_s4    <= ort_pkg::round_q16(dot_s3);
			c_s4[0] <= ort_pkg::round_q16(crs_s3[0]);
			c_s4[1] <= ort_pkg::round_q16(crs_s3[1]);
			c_s4[2] <= ort_pkg::round_q16(crs_s3[2]);
		end
		if (rdy_s5) begin
			idx_s5  <= idx_s4;
			dd_s5   <= d_s4.mag * d_s4.mag;
			gmag_s5 <= {kd, 1'b0};
			for (int i = 0; i < 3; i++) begin
				cmag_s5[i] <= c_s4[i].mag;
				neg_s5[i]  <= c_s4[i].neg ^ d_s4.neg;
			end
		end
		if (rdy_s6) begin
			idx_s6 <= idx_s5;
			e_s6   <= e_next;
		end
		if (rdy_s7) begin
			idx_s7 <= idx_s6;
			// k * e stays below 2^63, so the rounded energy always fits
			en_s7  <= esum[QSH+KW-1:QSH];
		end
		if (rdy_s8) begin
			idx_s8 <= idx_s7;
			en_s8  <= en_s7;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		ort_torque_lane u_lane (
			.clk       (clk),
			.ld        (ld),
			.gmag_s5   (gmag_s5),
			.cmag_s5   (cmag_s5[g]),
			.neg_s5    (neg_s5[g]),
			.torque_s8 (torque_s8[g])
		);
	end

	assign result.valid        = v_s8;
	assign result.result_index = idx_s8;
	assign result.energy       = en_s8;
	assign result.torque_x     = torque_s8[0];
	assign result.torque_y     = torque_s8[1];
	assign result.torque_z     = torque_s8[2];

	// an accepted request lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> v_s1)
		else $error("accepted request missing from first stage");

	// a blocked middle stage keeps its item
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !rdy_s5 |=> v_s4 && $stable(d_s4.mag) && $stable(idx_s4))
		else $error("stalled stage lost or changed its item");

	// no result appears without one behind it or one held
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s7 && !(v_s8 && !result.ready) |=> !v_s8)
		else $error("result valid without a source item");

endmodule

>>> verif/orientation_restraint_torque_checker.sv
// Result checker for the orientation restraint block: predicts energy and torque
// per request and compares them with what the block returns.
// Depends on ort_pkg and the ort_in_if, ort_out_if and ort_cfg_if interfaces.
`timescale 1ns / 1ps

module orientation_restraint_torque_checker (
	input  logic        clk,
	input  logic        arst_n,
	ort_in_if           item,
	ort_out_if          result,
	ort_cfg_if          cfg,
	output int unsigned errors,
	output int unsigned pending
);
	import ort_pkg::*;

	localparam longint unsigned UNIT_Q32     = 64'h1_0000_0000;
	localparam longint unsigned HALF_Q32     = 64'h8000_0000;
	localparam longint unsigned TORQUE_LIMIT = 64'h7FFF_FFFF;
	localparam longint unsigned PRODUCT_CAP  = 64'h8000_0000_0000_0000;

	typedef struct {
		longint x;
		longint y;
		longint z;
	} axis_q16_t;

	typedef struct {
		logic [IDXW-1:0]      index;
		logic [KW-1:0]        energy;
		logic signed [TW-1:0] tx;
		logic signed [TW-1:0] ty;
		logic signed [TW-1:0] tz;
	} torque_result_t;

	torque_result_t torque_queue[$];
	torque_result_t head;
	logic [KW-1:0]  restraint_k;
	int unsigned    mismatches;

	assign errors = mismatches;

	// shift right by n, rounding to nearest with ties away from zero
	function automatic longint round_shift(input longint v, input int unsigned n);
		longint unsigned m;
		if (v < 0) m = -v;
		else m = v;
		m = (m + (64'd1 << (n - 1))) >> n;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	// space-frame image of the body x axis, Q.16
	function automatic axis_q16_t body_x_axis(input logic signed [QW-1:0] qs,
		input logic signed [QW-1:0] qa, input logic signed [QW-1:0] qb,
		input logic signed [QW-1:0] qc);
		longint s, a, b, c;
		axis_q16_t n;
		s = qs;
		a = qa;
		b = qb;
		c = qc;
		n.x = round_shift(s * s + a * a - b * b - c * c, 12);
		n.y = round_shift(2 * (a * b + s * c), 12);
		n.z = round_shift(2 * (a * c - s * b), 12);
		return n;
	endfunction

	// g in Q.32 times cross component in Q.16, rounded to Q.16 and saturated
	function automatic logic signed [TW-1:0] scale_torque(input longint g, input longint c);
		longint unsigned mg, mc, r;
		bit neg;
		if (g < 0) mg = -g;
		else mg = g;
		if (c < 0) mc = -c;
		else mc = c;
		neg = (g < 0) != (c < 0);
		if (mg == 0 || mc == 0)
			return '0;
		if (mc > PRODUCT_CAP / mg) begin
			r = TORQUE_LIMIT;
		end else begin
			r = (mg * mc + HALF_Q32) >> 32;
			if (r > TORQUE_LIMIT)
				r = TORQUE_LIMIT;
		end
		return neg ? TW'(-longint'(r)) : TW'(longint'(r));
	endfunction

	function automatic torque_result_t restraint_response(input logic [KW-1:0] k);
		axis_q16_t nc, nr;
		longint d, g, cx, cy, cz;
		longint unsigned dd, e, en, kk;
		torque_result_t r;
		nc = body_x_axis(item.cur_s, item.cur_vx, item.cur_vy, item.cur_vz);
		nr = body_x_axis(item.ref_s, item.ref_vx, item.ref_vy, item.ref_vz);
		d = round_shift(nc.x * nr.x + nc.y * nr.y + nc.z * nr.z, 16);
		dd = d * d;
		// beyond unit alignment the energy factor bottoms out at zero
		e = (dd >= UNIT_Q32) ? 64'd0 : UNIT_Q32 - dd;
		kk = k;
		en = (kk * e + HALF_Q32) >> 32;
		if (en > TORQUE_LIMIT)
			en = TORQUE_LIMIT;
		cx = round_shift(nc.y * nr.z - nc.z * nr.y, 16);
		cy = round_shift(nc.z * nr.x - nc.x * nr.z, 16);
		cz = round_shift(nc.x * nr.y - nc.y * nr.x, 16);
		g = 2 * longint'(kk) * d;
		r.index = item.particle_index;
		r.energy = KW'(en);
		r.tx = scale_torque(g, cx);
		r.ty = scale_torque(g, cy);
		r.tz = scale_torque(g, cz);
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [IDXW-1:0] idx,
		input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: particle %0d %s expected %0d actual %0d",
				$time, idx, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_queue.delete();
			restraint_k = '0;
			mismatches = 0;
			pending <= 0;
		end else begin
			// retire before queueing, so a stray result never meets a fresh request
			if (result.valid && result.ready) begin
				if (torque_queue.size() == 0) begin
					mismatches++;
					$display("%0t: result for particle %0d expected none actual energy %0d",
						$time, result.result_index, result.energy);
				end else begin
					head = torque_queue.pop_front();
					compare_field("index", head.index, head.index, result.result_index);
					compare_field("energy", head.index, head.energy, result.energy);
					compare_field("torque_x", head.index, head.tx, result.torque_x);
					compare_field("torque_y", head.index, head.ty, result.torque_y);
					compare_field("torque_z", head.index, head.tz, result.torque_z);
				end
			end
			if (item.valid && item.ready)
				torque_queue.insert(torque_queue.size(), restraint_response(restraint_k));
			if (cfg.valid && cfg.ready)
				restraint_k = cfg.force_constant;
			pending <= torque_queue.size();
		end
	end

endmodule

>>> verif/orientation_restraint_torque_top_tb.sv
// Testbench top for the orientation restraint block: clock, reset, request and
// force-constant stimulus, result back-pressure and the final verdict.
// Depends on ort_pkg, the channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module orientation_restraint_torque_top_tb;
	import ort_pkg::*;

	localparam logic [KW-1:0] K_ONE       = 31'h0001_0000;
	localparam int            PHASES      = 6;
	localparam int            PHASE_ITEMS = 258;
	localparam int            IDLE_PCT    = 26;

	typedef struct packed {
		logic signed [QW-1:0] s;
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
	} quat_t;

	logic        clk;
	logic        arst_n;
	bit          steady;
	int unsigned errors;
	int unsigned pending;
	logic [KW-1:0] phase_k[PHASES];

	ort_in_if  item_ch();
	ort_out_if result_ch();
	ort_cfg_if cfg_ch();

	orientation_restraint_torque_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	orientation_restraint_torque_checker torque_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("orientation_restraint_torque_top test failed");
		$finish;
	end

	// result side: random back-pressure except in the steady stretch
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic quat_t quat(input int s, input int x, input int y, input int z);
		quat_t q;
		q.s = QW'(s);
		q.x = QW'(x);
		q.y = QW'(y);
		q.z = QW'(z);
		return q;
	endfunction

	function automatic int span();
		return int'($urandom_range(32768)) - 16384;
	endfunction

	function automatic quat_t random_unit_quat();
		real v[4];
		real norm;
		norm = 0.0;
		for (int i = 0; i < 4; i++) begin
			v[i] = real'(int'($urandom_range(65535)) - 32768);
			norm = norm + v[i] * v[i];
		end
		norm = $sqrt(norm);
		if (norm < 1.0)
			return quat(16384, 0, 0, 0);
		return quat($rtoi(v[0] / norm * 16384.0), $rtoi(v[1] / norm * 16384.0),
			$rtoi(v[2] / norm * 16384.0), $rtoi(v[3] / norm * 16384.0));
	endfunction

	// small tilt away from a given orientation
	function automatic quat_t nudge_quat(input quat_t q);
		return quat(q.s + int'($urandom_range(600)) - 300, q.x + int'($urandom_range(600)) - 300,
			q.y + int'($urandom_range(600)) - 300, q.z + int'($urandom_range(600)) - 300);
	endfunction

	// called at a rising edge; returns at the edge where the request is taken
	task automatic push_request(input logic [IDXW-1:0] idx, input quat_t cq, input quat_t tq);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.particle_index <= idx;
		item_ch.cur_s          <= cq.s;
		item_ch.cur_vx         <= cq.x;
		item_ch.cur_vy         <= cq.y;
		item_ch.cur_vz         <= cq.z;
		item_ch.ref_s          <= tq.s;
		item_ch.ref_vx         <= tq.x;
		item_ch.ref_vy         <= tq.y;
		item_ch.ref_vz         <= tq.z;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic push_random();
		quat_t cq, tq;
		int pick;
		pick = $urandom_range(99);
		if (pick < 50) begin
			cq = random_unit_quat();
			tq = $urandom_range(1) ? nudge_quat(cq) : random_unit_quat();
		end else if (pick < 80) begin
			cq = quat(span(), span(), span(), span());
			tq = quat(span(), span(), span(), span());
		end else begin
			cq = {$urandom, $urandom};
			tq = {$urandom, $urandom};
		end
		push_request(IDXW'($urandom), cq, tq);
	endtask

	// hold until every queued request has produced its result
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_force_constant(input logic [KW-1:0] k);
		cfg_ch.force_constant <= k;
		cfg_ch.valid          <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		arst_n                 = 1'b0;
		steady                 = 1'b0;
		item_ch.valid          = 1'b0;
		item_ch.particle_index = '0;
		item_ch.cur_s          = '0;
		item_ch.cur_vx         = '0;
		item_ch.cur_vy         = '0;
		item_ch.cur_vz         = '0;
		item_ch.ref_s          = '0;
		item_ch.ref_vx         = '0;
		item_ch.ref_vy         = '0;
		item_ch.ref_vz         = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.force_constant  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_force_constant(K_ONE);
		// aligned, opposed, perpendicular, zero, out-of-range and saturating cases
		push_request(16'h0000, quat(16384, 0, 0, 0), quat(16384, 0, 0, 0));
		push_request(16'hFFFF, quat(16384, 0, 0, 0), quat(0, 0, 0, 16384));
		push_request(16'h0001, quat(16384, 0, 0, 0), quat(11585, 0, 0, 11585));
		push_request(16'h0002, quat(11585, 0, 11585, 0), quat(11585, 0, 0, 11585));
		push_request(16'h0003, quat(16384, 0, 0, 0), quat(11585, 11585, 0, 0));
		push_request(16'h0004, quat(16384, 16384, 16384, 16384),
			quat(16384, 16384, 16384, 16384));
		push_request(16'h0005, quat(-16384, -16384, -16384, -16384),
			quat(16384, 16384, 16384, 16384));
		push_request(16'h7FFF, quat(32767, 32767, 32767, 32767),
			quat(-32768, -32768, -32768, -32768));
		push_request(16'h8000, quat(-32768, -32768, -32768, -32768),
			quat(-32768, -32768, -32768, -32768));
		push_request(16'h0006, quat(0, 0, 0, 0), quat(16384, 0, 0, 0));
		push_request(16'h0007, quat(0, 0, 0, 0), quat(0, 0, 0, 0));
		push_request(16'h0008, quat(32767, -32768, 32767, -32768),
			quat(-32768, 32767, 0, 16384));
		push_request(16'h0009, quat(8192, 0, 0, 0), quat(16384, 0, 0, 0));
		push_request(16'h000A, quat(0, 16384, 0, 0), quat(0, 0, 16384, 0));
		push_request(16'h000B, quat(0, 0, 0, 16384), quat(0, 0, 16384, 0));
		push_request(16'h000C, quat(11585, -11585, 0, 0), quat(8192, 8192, 8192, 8192));
		push_request(16'h000D, quat(-16384, 0, 0, 0), quat(16384, 0, 0, 0));
		push_request(16'h000E, quat(8192, 8192, 8192, 8192), quat(11585, 0, 11585, 0));
		push_request(16'h000F, quat(16384, -16384, 16384, -16384),
			quat(-32768, 0, 32767, 0));
		push_request(16'hA5A5, random_unit_quat(), random_unit_quat());
		item_ch.valid <= 1'b0;

		phase_k[0] = '0;
		phase_k[1] = TQ_MAX;
		phase_k[2] = KW'(1);
		phase_k[3] = K_ONE;
		phase_k[4] = KW'($urandom);
		phase_k[5] = KW'($urandom_range(1 << 20));
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_force_constant(phase_k[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				steady = (p == 3) && (i < 150);
				if (p == 4 && i == 130) begin
					item_ch.valid <= 1'b0;
					wait_drained();
				end
				push_random();
			end
			item_ch.valid <= 1'b0;
		end
		steady = 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("orientation_restraint_torque_top test passed");
		else
			$display("orientation_restraint_torque_top test failed");
		$finish;
	end

endmodule

>>> files.f
rtl/core/ort_pkg.sv
rtl/core/ort_in_if.sv
rtl/core/ort_out_if.sv
rtl/core/ort_cfg_if.sv
rtl/core/ort_torque_lane.sv
rtl/core/orientation_restraint_torque_top.sv
verif/orientation_restraint_torque_checker.sv
verif/orientation_restraint_torque_top_tb.sv
